/* hdl/ibc_pkg.sv */
// Shared types and constants for the IMU bias calibration block.
package ibc_pkg;

  localparam int NUM_AXES = 6;
  localparam int AXIS_W   = 16;
  localparam int CORR_W   = AXIS_W + 1;
  localparam int CNT_W    = 16;
  localparam int SETTLE_W = 15;

  // Axes whose correction is offset minus raw (X and Y acceleration)
  localparam logic [NUM_AXES-1:0] OFFSET_MINUS_RAW = 6'b000011;
  localparam int AXIS_ACCEL_Z = 2;

  // Calibration phases
  localparam logic [1:0] PHASE_START  = 2'd0;
  localparam logic [1:0] PHASE_SETTLE = 2'd1;
  localparam logic [1:0] PHASE_SUM    = 2'd2;

  // Configuration register indexes
  localparam logic REG_SETTLE  = 1'b0;
  localparam logic REG_GRAVITY = 1'b1;

  localparam logic [SETTLE_W-1:0] SETTLE_RESET  = 15'd250;
  localparam logic [AXIS_W-1:0]   GRAVITY_RESET = 16'd16384;

  typedef logic [AXIS_W-1:0] axis_word_t;
  typedef axis_word_t [NUM_AXES-1:0] axis_vec_t;
  typedef logic [CORR_W-1:0] corr_word_t;
  typedef corr_word_t [NUM_AXES-1:0] corr_vec_t;

  typedef struct packed {
    logic adv;
    logic accept;
  } ibc_pipe_ctl_t;

endpackage

/* hdl/imu_bias_calibration.sv */
// Top level of the IMU bias calibration block.
//
//  channel | direction | tdata (low bit up)                          | tuser
//  s_      | in        | accel_x,y,z, rate_x,y,z (16 b signed each)  | cal_request
//  m_      | out       | corr_accel_x,y,z, corr_rate_x,y,z (17 b)    | calibrating
//  cfg_    | in        | index 0 settle_samples, 1 gravity_counts    | -
//
// One transaction per cycle unless stalled, via the sample and output registers.
// Calibration state and offsets update at input acceptance; the output stage
// subtracts the updated offsets from that same sample. The whole two-stage pipe
// stalls while the output register is full and not taken. Synchronous reset clears
// valids and calibration state but not the subtractor offsets; no clearing pass.
module imu_bias_calibration
  import ibc_pkg::*;
#(
  parameter int AVG_SHIFT = 6
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [95:0]  s_tdata,   // accel_x, accel_y, accel_z, rate_x, rate_y, rate_z
  input  logic         s_tuser,   // cal_request
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [103:0] m_tdata,   // corr_accel_x/y/z, corr_rate_x/y/z, 2 b zero pad
  output logic         m_tuser,   // calibrating
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [15:0]  cfg_data
);

  ibc_pipe_ctl_t ctl;
  axis_vec_t     raw;
  axis_vec_t     offsets_next;
  logic          armed_next;
  corr_vec_t     corr;

  assign raw        = axis_vec_t'(s_tdata);
  assign ctl.adv    = !m_tvalid || m_tready;
  assign ctl.accept = s_tvalid && ctl.adv;
  assign s_tready   = ctl.adv;
  assign m_tdata    = {2'b00, corr};

  ibc_cal_ctrl #(
    .AVG_SHIFT(AVG_SHIFT)
  ) u_cal_ctrl (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .accept       (ctl.accept),
    .raw          (raw),
    .cal_request  (s_tuser),
    .offsets_next (offsets_next),
    .armed_next   (armed_next)
  );

  axis_vec_t offsets;

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      offsets <= offsets_next;
    end
  end

  ibc_corr u_corr (
    .clk            (clk),
    .rst            (rst),
    .ctl            (ctl),
    .raw            (raw),
    .calibrating_in (armed_next),
    .offsets        (offsets),
    .corr           (corr),
    .calibrating    (m_tuser),
    .out_valid      (m_tvalid)
  );

endmodule

/* hdl/ibc_cal_ctrl.sv */
// Calibration sequencer, per-axis sum accumulators, offsets and config registers.
module ibc_cal_ctrl
  import ibc_pkg::*;
#(
  parameter int AVG_SHIFT = 6
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        accept,
  input  axis_vec_t   raw,
  input  logic        cal_request,
  output axis_vec_t   offsets_next,
  output logic        armed_next
);

  localparam int SUM_W = AXIS_W + AVG_SHIFT;
  localparam logic [CNT_W-1:0] AVG_COUNT = CNT_W'(1 << AVG_SHIFT);

  logic [SETTLE_W-1:0] settle_samples;
  axis_word_t          gravity_counts;
  logic                armed;
  logic [1:0]          phase;
  logic [1:0]          phase_next;
  logic [CNT_W-1:0]    sample_count;
  logic [CNT_W-1:0]    sample_count_next;
  logic [CNT_W-1:0]    count_inc;
  logic [NUM_AXES-1:0][SUM_W-1:0] sums;
  logic [NUM_AXES-1:0][SUM_W-1:0] sums_next;
  logic [NUM_AXES-1:0][SUM_W-1:0] sums_add;
  axis_vec_t           offsets;
  axis_vec_t           avg;
  logic                armed_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      settle_samples <= SETTLE_RESET;
      gravity_counts <= GRAVITY_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SETTLE:  settle_samples <= cfg_data[SETTLE_W-1:0];
        REG_GRAVITY: gravity_counts <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    count_inc = sample_count + CNT_W'(1);
    for (int i = 0; i < NUM_AXES; i++) begin
      sums_add[i] = sums[i] + {{AVG_SHIFT{raw[i][AXIS_W-1]}}, raw[i]};
      avg[i]      = sums_add[i][SUM_W-1:AVG_SHIFT];
    end
    avg[AXIS_ACCEL_Z] = sums_add[AXIS_ACCEL_Z][SUM_W-1:AVG_SHIFT] + gravity_counts;
  end

  always_comb begin
    armed_eff         = armed | cal_request;
    armed_next        = armed_eff;
    phase_next        = phase;
    sample_count_next = sample_count;
    sums_next         = sums;
    offsets_next      = offsets;
    if (armed_eff) begin
      unique case (phase)
        PHASE_START: begin
          sample_count_next = CNT_W'(settle_samples);
          sums_next         = '0;
          phase_next        = PHASE_SETTLE;
        end
        PHASE_SETTLE: begin
          if (sample_count <= CNT_W'(1)) begin
            sample_count_next = '0;
            phase_next        = PHASE_SUM;
          end else begin
            sample_count_next = sample_count - CNT_W'(1);
          end
        end
        PHASE_SUM: begin
          sums_next         = sums_add;
          sample_count_next = count_inc;
          if (count_inc >= AVG_COUNT) begin
            offsets_next = avg;
            phase_next   = PHASE_START;
            armed_next   = 1'b0;
          end
        end
        default: phase_next = PHASE_START;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      armed        <= 1'b0;
      phase        <= PHASE_START;
      sample_count <= '0;
      sums         <= '0;
      offsets      <= '0;
    end else if (accept) begin
      armed        <= armed_next;
      phase        <= phase_next;
      sample_count <= sample_count_next;
      sums         <= sums_next;
      offsets      <= offsets_next;
    end
  end

endmodule

/* hdl/ibc_corr.sv */
// Sample register and corrected-output register with the six offset subtractors.
module ibc_corr
  import ibc_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  ibc_pipe_ctl_t ctl,
  input  axis_vec_t     raw,
  input  logic          calibrating_in,
  input  axis_vec_t     offsets,
  output corr_vec_t     corr,
  output logic          calibrating,
  output logic          out_valid
);

  logic      mid_valid;
  axis_vec_t mid_raw;
  logic      mid_cal;
  corr_vec_t corr_next;

  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      if (OFFSET_MINUS_RAW[i]) begin
        corr_next[i] = {offsets[i][AXIS_W-1], offsets[i]}
                     - {mid_raw[i][AXIS_W-1], mid_raw[i]};
      end else begin
        corr_next[i] = {mid_raw[i][AXIS_W-1], mid_raw[i]}
                     - {offsets[i][AXIS_W-1], offsets[i]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
      out_valid <= 1'b0;
    end else if (ctl.adv) begin
      mid_valid <= ctl.accept;
      out_valid <= mid_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      mid_raw     <= raw;
      mid_cal     <= calibrating_in;
      corr        <= corr_next;
      calibrating <= mid_cal;
    end
  end

endmodule

/* hdl/ibc_checker.sv */
// Port-level checker for the IMU bias calibration block, bound to the top level.
module ibc_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [103:0] m_tdata,
  input logic         m_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("output changed while stalled");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output register");

  a_stall_backpressure: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !s_tready)
    else $error("input accepted while output stalled");

  a_result_has_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
    else $error("result without matching input transaction");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[103:102] == 2'b00)
    else $error("output padding not zero");

endmodule

bind imu_bias_calibration ibc_checker u_ibc_checker (.*);
